### rtl/core/sonar_obstacle_avoid_defines.svh
// Assertion macros shared by the sonar obstacle avoidance RTL.
// Expects clk and arst_n in the scope of each use.
`ifndef SONAR_OBSTACLE_AVOID_DEFINES_SVH
`define SONAR_OBSTACLE_AVOID_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SOA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define SOA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SOA_ASSERT_IMP(label, ante, cons, msg)
`define SOA_ASSERT_NXT(label, ante, cons, msg)
`endif
`endif

### rtl/core/soa_pkg.sv
// Package for the sonar obstacle avoidance block: sizes, beat types, register codes.
// No dependencies.
package soa_pkg;

	localparam int NUM_SONARS = 32;
	localparam int IDX_W      = $clog2(NUM_SONARS);
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam logic [4:0]         RIGHT_SONAR_RST = 5'd31;
	localparam logic signed [15:0] SPEED_MIN       = 16'sh8000;
	localparam logic signed [15:0] SPEED_MAX       = 16'sh7FFF;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LEFT_SONAR    = 3'd0,
		REG_RIGHT_SONAR   = 3'd1,
		REG_MIN_DISTANCE  = 3'd2,
		REG_HALT_DISTANCE = 3'd3,
		REG_CRUISE_SPEED  = 3'd4,
		REG_TURN_RATE     = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [4:0]         left_sonar;
		logic [4:0]         right_sonar;
		logic [15:0]        min_distance;
		logic [15:0]        halt_distance;
		logic signed [15:0] cruise_speed;
		logic signed [15:0] turn_rate;
	} cfg_t;

	typedef struct packed {
		logic [4:0]  sensor_index;
		logic [15:0] range_value;
		logic        bunch_end;
	} in_item_t;

	typedef struct packed {
		logic               active;
		logic signed [15:0] translation;
		logic signed [15:0] rotation;
	} out_item_t;

	// Classified reading as it travels from front to back.
	typedef struct packed {
		logic        store;
		logic        trigger;
		idx_t        addr;
		logic [15:0] range_value;
	} q_entry_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SCAN,
		BK_WAIT,
		BK_DECIDE
	} back_state_t;

	function automatic idx_t clamp_index(logic [4:0] v);
		idx_t r;
		if (int'(v) >= NUM_SONARS) begin
			r = IDX_W'(NUM_SONARS - 1);
		end else begin
			r = IDX_W'(v);
		end
		return r;
	endfunction

	function automatic idx_t abs_diff(idx_t a, idx_t b);
		idx_t r;
		if (a > b) begin
			r = a - b;
		end else begin
			r = b - a;
		end
		return r;
	endfunction

endpackage

### rtl/core/sonar_obstacle_avoid.sv
// Top level of the sonar obstacle avoidance block: front, queue and back joined.
// Depends on soa_pkg, soa_front, soa_queue and soa_back.
//
//  channel  signals                          direction  beat when
//  item     item_valid, item_stall, item     in         item_valid && !item_stall
//  result   result_valid, result_stall, result  out     result_valid && !result_stall
//  config   wr_en, wr_index, wr_data         in         wr_en
//
// A reading without bunch end is popped and stored while the back end idles; readings
// queue two deep. A bunch end is popped, then the range table is read once per window
// sonar through its single read port, then the reads drain and the decision is made.
// Reset clears the table through per-entry valid flags; no clearing pass is needed.
// A stalled result holds in its output register; the back end works on up to decide.
module sonar_obstacle_avoid (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  soa_pkg::in_item_t   item,
	output logic                result_valid,
	input  logic                result_stall,
	output soa_pkg::out_item_t  result,
	input  logic                wr_en,
	input  logic [2:0]          wr_index,
	input  logic [15:0]         wr_data
);
	import soa_pkg::*;

	cfg_t     cfg;
	q_entry_t push_entry;
	q_entry_t head;
	logic     push;
	logic     pop;
	logic     empty;
	logic     full;

	soa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.full       (full),
		.push       (push),
		.push_entry (push_entry),
		.cfg        (cfg)
	);

	soa_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	soa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.head         (head),
		.empty        (empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

### rtl/core/soa_front.sv
// Front end: configuration registers, reading accept and classification.
// Depends on soa_pkg; feeds soa_queue.
module soa_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  soa_pkg::in_item_t  item,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [15:0]        wr_data,
	input  logic               full,
	output logic               push,
	output soa_pkg::q_entry_t  push_entry,
	output soa_pkg::cfg_t      cfg
);
	import soa_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.left_sonar    <= '0;
			cfg_q.right_sonar   <= RIGHT_SONAR_RST;
			cfg_q.min_distance  <= '0;
			cfg_q.halt_distance <= '0;
			cfg_q.cruise_speed  <= '0;
			cfg_q.turn_rate     <= '0;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_LEFT_SONAR:    cfg_q.left_sonar    <= wr_data[4:0];
				REG_RIGHT_SONAR:   cfg_q.right_sonar   <= wr_data[4:0];
				REG_MIN_DISTANCE:  cfg_q.min_distance  <= wr_data;
				REG_HALT_DISTANCE: cfg_q.halt_distance <= wr_data;
				REG_CRUISE_SPEED:  cfg_q.cruise_speed  <= wr_data;
				REG_TURN_RATE:     cfg_q.turn_rate     <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg        = cfg_q;
	assign item_stall = full;
	assign push       = item_valid && !full;

	// Drop the table write for readings of a sonar past the table; still trigger.
	always_comb begin
		push_entry.store       = int'(item.sensor_index) < NUM_SONARS;
		push_entry.trigger     = item.bunch_end;
		push_entry.addr        = IDX_W'(item.sensor_index);
		push_entry.range_value = item.range_value;
	end

endmodule

### rtl/core/soa_queue.sv
// Short queue of classified readings between front and back.
// Depends on soa_pkg and the assertion macro header.
`include "sonar_obstacle_avoid_defines.svh"
module soa_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  soa_pkg::q_entry_t  push_entry,
	input  logic               pop,
	output soa_pkg::q_entry_t  head,
	output logic               empty,
	output logic               full
);
	import soa_pkg::*;

	q_entry_t             ent_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_CNT_W-1:0]   cnt_q;

	function automatic logic [Q_PTR_W-1:0] ptr_next(logic [Q_PTR_W-1:0] p);
		logic [Q_PTR_W-1:0] r;
		if (p == Q_PTR_W'(Q_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign head  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`SOA_ASSERT_IMP(a_q_no_overflow, push, cnt_q < Q_CNT_W'(Q_DEPTH), "queue push while full")
	`SOA_ASSERT_IMP(a_q_no_underflow, pop, cnt_q != '0, "queue pop while empty")

endmodule

### rtl/core/soa_back.sv
// Back end: range table, window scan for the nearest range, decision and result register.
// Depends on soa_pkg and the assertion macro header; fed by soa_queue.
`include "sonar_obstacle_avoid_defines.svh"
module soa_back (
	input  logic               clk,
	input  logic               arst_n,
	input  soa_pkg::cfg_t      cfg,
	input  soa_pkg::q_entry_t  head,
	input  logic               empty,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output soa_pkg::out_item_t result
);
	import soa_pkg::*;

	back_state_t state_q, state_d;

	logic [15:0]     mem [NUM_SONARS];
	logic [NUM_SONARS-1:0] vld_q;

	idx_t        k_q;
	logic        rd_vld_s1;
	idx_t        rd_idx_s1;
	logic        rd_first_s1;
	logic [15:0] mem_rd_s1;
	logic        vld_rd_s1;
	logic [15:0] rd_data;
	logic [15:0] min_q;
	idx_t        id_q;

	logic        out_valid_q;
	out_item_t   out_q;

	idx_t        l, r, lo, hi;
	logic        out_free;
	logic        issue;
	logic        load;
	logic        tbl_wr;
	out_item_t   decision;
	idx_t        dl, dr;

	// Window bounds: saturated, then ordered.
	always_comb begin
		l = clamp_index(cfg.left_sonar);
		r = clamp_index(cfg.right_sonar);
		if (l > r) begin
			lo = r;
			hi = l;
		end else begin
			lo = l;
			hi = r;
		end
	end

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty && head.trigger) begin
					state_d = BK_SCAN;
				end
			end
			BK_SCAN: begin
				if (k_q == hi) begin
					state_d = BK_WAIT;
				end
			end
			BK_WAIT: state_d = BK_DECIDE;
			BK_DECIDE: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		pop   = 1'b0;
		issue = 1'b0;
		load  = 1'b0;
		unique case (state_q)
			BK_IDLE:   pop   = !empty;
			BK_SCAN:   issue = 1'b1;
			BK_WAIT: begin
			end
			BK_DECIDE: load  = out_free;
			default: begin
			end
		endcase
	end

	assign tbl_wr = pop && head.store;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			if (tbl_wr) begin
				vld_q[head.addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			mem[head.addr] <= head.range_value;
		end
		if (issue) begin
			mem_rd_s1 <= mem[k_q];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			k_q <= lo;
		end else if (issue) begin
			k_q <= k_q + 1'b1;
		end
		if (issue) begin
			vld_rd_s1   <= vld_q[k_q];
			rd_idx_s1   <= k_q;
			rd_first_s1 <= (k_q == lo);
		end
	end

	// Never-written entries read as the reset range of zero.
	assign rd_data = vld_rd_s1 ? mem_rd_s1 : '0;

	// Strict compare in ascending order keeps the lowest index on a tie.
	always_ff @(posedge clk) begin
		if (rd_vld_s1 && (rd_first_s1 || rd_data < min_q)) begin
			min_q <= rd_data;
			id_q  <= rd_idx_s1;
		end
	end

	always_comb begin
		dl = abs_diff(l, id_q);
		dr = abs_diff(r, id_q);
		decision.active      = min_q < cfg.min_distance;
		decision.translation = '0;
		decision.rotation    = '0;
		if (decision.active) begin
			if (min_q >= cfg.halt_distance) begin
				decision.translation = cfg.cruise_speed;
			end
			if (dl > dr) begin
				decision.rotation = cfg.turn_rate;
			end else if (cfg.turn_rate == SPEED_MIN) begin
				decision.rotation = SPEED_MAX;
			end else begin
				decision.rotation = -cfg.turn_rate;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= decision;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	`SOA_ASSERT_IMP(a_scan_in_window, state_q == BK_SCAN, k_q >= lo && k_q <= hi, "scan index left the window")
	`SOA_ASSERT_IMP(a_read_in_scan, rd_vld_s1, state_q == BK_SCAN || state_q == BK_WAIT, "table read outside scan")
	`SOA_ASSERT_NXT(a_scan_drains, state_q == BK_WAIT, state_q == BK_DECIDE && !rd_vld_s1, "scan did not drain")

endmodule
